[design/hlt_pkg.sv]
// Package: types, constants and event codes for the heartbeat liveness table.
package hlt_pkg;

	localparam int Nodes = 32;
	localparam int IdxW = $clog2(Nodes);
	localparam int CntW = $clog2(Nodes + 1);

	localparam logic [7:0] DeathCountRst = 8'd3;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_STARTED = 3'd1;
	localparam logic [2:0] EV_STOPPED = 3'd2;
	localparam logic [2:0] EV_DIED    = 3'd3;
	localparam logic [2:0] EV_FULL    = 3'd4;

	localparam logic [1:0] SIGN_START = 2'd0;
	localparam logic [1:0] SIGN_ALIVE = 2'd1;
	localparam logic [1:0] SIGN_STOP  = 2'd2;
	localparam logic [1:0] SIGN_BAD   = 2'd3;

	typedef struct packed {
		logic        mode;
		logic [1:0]  sign;
		logic [31:0] node_id;
		logic [31:0] sender_address;
		logic [31:0] beat_interval;
		logic [47:0] now_time;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [31:0] event_node;
		logic [31:0] event_address;
		logic [47:0] event_time;
		logic [5:0]  alive_total;
		logic [5:0]  dead_total;
		logic        last;
	} out_beat_t;

	// controller -> datapath commands
	typedef struct packed {
		logic            load;     // capture input beat
		logic            scan_clr; // reset scan index and search result
		logic            scan_step;// examine entry at index, advance
		logic            do_new;   // write new entry at free slot
		logic            do_stop;  // free found entry
		logic            do_die;   // mark found / scanned entry dead
		logic            do_seen;  // refresh found entry time
		logic            use_scan; // die target is scan index, else found slot
		logic [2:0]      ev;       // event code of the result
		logic            ev_stored;// result carries stored node/address
		logic            ev_zero;  // result carries zero node/address
		logic            ev_last;
		logic            emit;     // load output register
	} hlt_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic mode;
		logic [1:0] sign;
		logic scan_done;  // index has passed the last entry
		logic hit;        // key found
		logic hit_dead;
		logic hit_over;   // found entry is overdue
		logic free_ok;    // a free slot exists
		logic cur_over;   // scanned entry is live and overdue
	} hlt_sts_t;

endpackage

[design/heartbeat_liveness_table.sv]
// Heartbeat liveness table.
// Input channel (in_valid/in_ready/in_data) takes one beat per heartbeat or
// check request; it is accepted only when the block is idle.
// Output channel (out_valid/out_ready/out_data) gives one result beat per
// heartbeat, or one died beat per overdue live node then a final beat for a
// check; out_data.last marks the final beat.
// Heartbeat: a capture step, a key/free-slot scan over the 32 entries and a
// done step, then a decide step that waits for a free output register and
// emits the result; the next item is accepted once the block is idle again.
// Check: a capture step, then a scan of every table entry, loading a died beat
// into the output register for each live overdue entry as it is reached, and
// a final step for the final beat; a stalled receiver makes the check longer.
// Configuration: cfg_valid/cfg_ready write death_count; always ready. The user
// must write it only while idle; the block itself does not enforce this.
// Reset clears the table, the counters, and death_count to 3.
// When the receiver stalls, the single output register holds its beat, and
// decide, or a check scan at an overdue entry or its end, waits until taken.
module heartbeat_liveness_table import hlt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0] cfg_data
);

	logic [7:0] death_count_q;
	hlt_cmd_t cmd;
	hlt_sts_t sts;

	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) death_count_q <= DeathCountRst;
		else if (cfg_valid) death_count_q <= cfg_data;
	end

	hlt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	hlt_datapath u_dp (
		.clk, .arst_n, .death_count(death_count_q), .in_data, .cmd, .sts, .out_data
	);

endmodule

[design/hlt_datapath.sv]
// Datapath: entry store, scan index, overdue compare, counters and output register.
module hlt_datapath import hlt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] death_count,
	input  in_beat_t   in_data,
	input  hlt_cmd_t   cmd,
	output hlt_sts_t   sts,
	output out_beat_t  out_data
);

	logic [Nodes-1:0] used_q, dead_q;
	logic [31:0] key_q   [Nodes];
	logic [31:0] addr_q  [Nodes];
	logic [47:0] limit_q [Nodes];
	logic [47:0] seen_q  [Nodes];

	in_beat_t      item_q;
	logic [IdxW:0] idx_q;
	logic [IdxW-1:0] hit_idx_q, free_idx_q;
	logic          hit_q, free_q;
	logic [47:0]   lim_q;
	logic [CntW-1:0] live_q, dead_cnt_q;

	logic [IdxW-1:0] ix, tgt;
	logic [47:0] cur_gap, hit_gap;
	logic [39:0] prod;
	logic [7:0]  dc;

	assign ix = idx_q[IdxW-1:0];
	assign tgt = cmd.use_scan ? ix : hit_idx_q;
	assign cur_gap = item_q.now_time - seen_q[ix];
	assign hit_gap = item_q.now_time - seen_q[hit_idx_q];
	assign dc = (death_count == 8'd0) ? 8'd1 : death_count;
	assign prod = dc * in_data.beat_interval;

	always_comb begin
		sts.mode = item_q.mode;
		sts.sign = item_q.sign;
		sts.scan_done = (idx_q == (IdxW+1)'(Nodes));
		sts.hit = hit_q;
		sts.hit_dead = dead_q[hit_idx_q];
		sts.hit_over = hit_gap > limit_q[hit_idx_q];
		sts.free_ok = free_q;
		sts.cur_over = used_q[ix] && !dead_q[ix] && (cur_gap > limit_q[ix]);
	end

	// control state: valid bits, counters, search results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			dead_q <= '0;
			live_q <= '0;
			dead_cnt_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
		end else begin
			if (cmd.scan_clr) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (used_q[ix] && key_q[ix] == item_q.node_id && !hit_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= ix;
				end
				if (!used_q[ix] && !free_q) begin
					free_q <= 1'b1;
					free_idx_q <= ix;
				end
			end
			if (cmd.do_new) begin
				used_q[free_idx_q] <= 1'b1;
				dead_q[free_idx_q] <= 1'b0;
				live_q <= live_q + 1'b1;
			end
			if (cmd.do_stop) begin
				used_q[hit_idx_q] <= 1'b0;
				if (dead_q[hit_idx_q]) dead_cnt_q <= dead_cnt_q - 1'b1;
				else live_q <= live_q - 1'b1;
			end
			if (cmd.do_die) begin
				dead_q[tgt] <= 1'b1;
				live_q <= live_q - 1'b1;
				dead_cnt_q <= dead_cnt_q + 1'b1;
			end
		end
	end

	// payload: item, limit, entry fields, output
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			lim_q <= (prod > 40'hFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : {8'd0, prod};
		end
		if (cmd.do_new) begin
			key_q[free_idx_q] <= item_q.node_id;
			addr_q[free_idx_q] <= item_q.sender_address;
			limit_q[free_idx_q] <= lim_q;
			seen_q[free_idx_q] <= item_q.now_time;
		end
		if (cmd.do_seen) seen_q[hit_idx_q] <= item_q.now_time;
		if (cmd.emit) begin
			out_data.event_res <= cmd.ev;
			out_data.event_node <= cmd.ev_zero ? 32'd0 :
				(cmd.ev_stored ? key_q[tgt] : item_q.node_id);
			out_data.event_address <= cmd.ev_zero ? 32'd0 :
				(cmd.ev_stored ? addr_q[tgt] : item_q.sender_address);
			out_data.event_time <= item_q.now_time;
			out_data.alive_total <= 6'(cmd.do_new ? live_q + 1'b1 :
				((cmd.do_die || (cmd.do_stop && !dead_q[hit_idx_q])) ? live_q - 1'b1 : live_q));
			out_data.dead_total <= 6'(cmd.do_die ? dead_cnt_q + 1'b1 :
				((cmd.do_stop && dead_q[hit_idx_q]) ? dead_cnt_q - 1'b1 : dead_cnt_q));
			out_data.last <= cmd.ev_last;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(live_q) + 32'(dead_cnt_q)) <= Nodes) else $error("count overflow");
	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(live_q) + 32'(dead_cnt_q)) == $countones(used_q)) else $error("count mismatch");
	a_new_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_new |-> free_q && !used_q[free_idx_q]) else $error("new on used slot");
`endif

endmodule

[design/hlt_ctrl.sv]
// Controller: sequences lookup scans, check scans and result beats.
module hlt_ctrl import hlt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  hlt_sts_t  sts,
	output hlt_cmd_t  cmd
);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_CHECK, S_WAIT} state_t;
	state_t state_q;
	logic ov_q;
	logic out_free;

	assign out_free = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				cmd.scan_clr = in_valid;
			end
			S_SCAN: cmd.scan_step = !sts.scan_done;
			S_DECIDE: if (out_free) begin
				cmd.emit = 1'b1;
				cmd.ev_last = 1'b1;
				if (sts.sign == SIGN_BAD) cmd.ev = EV_NONE;
				else if (sts.sign == SIGN_STOP) begin
					if (sts.hit) begin
						cmd.do_stop = 1'b1;
						if (!sts.hit_dead) begin
							cmd.ev = EV_STOPPED;
							cmd.ev_stored = 1'b1;
						end
					end
				end else if (!sts.hit) begin
					if (sts.free_ok) begin
						cmd.do_new = 1'b1;
						cmd.ev = EV_STARTED;
					end else cmd.ev = EV_FULL;
				end else if (sts.hit_dead) cmd.ev = EV_NONE;
				else if (sts.hit_over) begin
					cmd.do_die = 1'b1;
					cmd.ev = EV_DIED;
					cmd.ev_stored = 1'b1;
				end else cmd.do_seen = 1'b1;
			end
			S_CHECK: begin
				cmd.use_scan = 1'b1;
				if (sts.scan_done) begin
					if (out_free) begin
						cmd.emit = 1'b1;
						cmd.ev_zero = 1'b1;
						cmd.ev_last = 1'b1;
					end
				end else if (!sts.cur_over) cmd.scan_step = 1'b1;
				else if (out_free) begin
					cmd.emit = 1'b1;
					cmd.do_die = 1'b1;
					cmd.ev = EV_DIED;
					cmd.ev_stored = 1'b1;
					cmd.scan_step = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// state and output-valid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (cmd.emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_WAIT;
				S_WAIT: state_q <= sts.mode ? S_CHECK : S_SCAN;
				S_SCAN: if (sts.scan_done) state_q <= S_DECIDE;
				S_DECIDE: if (out_free) state_q <= S_IDLE;
				S_CHECK: if (sts.scan_done && out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free) else $error("overwrite of pending result");
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_WAIT) else $error("bad accept");
	a_one_die: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_die |-> cmd.emit) else $error("death without result");
`endif

endmodule
